/* hdl/rcm_pkg.sv */
// ----------------------------------------------------------------------------
// rcm_pkg: shared types and AES helpers for the response CBC-MAC engine
// Command codes, queue entry layout, S-box, round and key-step functions.
// ----------------------------------------------------------------------------
`default_nettype none
package rcm_pkg;

	localparam logic [1:0] ACT_BEGIN  = 2'd0;
	localparam logic [1:0] ACT_CIPHER = 2'd1;
	localparam logic [1:0] ACT_END    = 2'd2;

	localparam logic [0:0] REG_KEY_HIGH = 1'b0;
	localparam logic [0:0] REG_KEY_LOW  = 1'b1;

	localparam logic [127:0] DOMAIN_BLOCK = 128'h54484438392D5253_502D4D41432D5631;
	localparam logic [7:0]   PAD_MARK     = 8'h80;
	localparam logic [12:0]  COUNT_MAX    = 13'd8191;
	localparam logic [3:0]   LAST_ROUND   = 4'd10;

	typedef enum logic [1:0] {
		OP_BEGIN   = 2'd0,
		OP_CIPHER  = 2'd1,
		OP_END_OK  = 2'd2,
		OP_END_ERR = 2'd3
	} rcm_op_t;

	typedef struct packed {
		rcm_op_t      op;
		logic [127:0] blk;   // transaction or ciphertext block
		logic [63:0]  ctx;   // high half of context or status block
	} rcm_cmd_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] rcon(input logic [3:0] r);
		logic [7:0] v;
		begin
			unique case (r)
				4'd1:    v = 8'h01;
				4'd2:    v = 8'h02;
				4'd3:    v = 8'h04;
				4'd4:    v = 8'h08;
				4'd5:    v = 8'h10;
				4'd6:    v = 8'h20;
				4'd7:    v = 8'h40;
				4'd8:    v = 8'h80;
				4'd9:    v = 8'h1b;
				4'd10:   v = 8'h36;
				default: v = 8'h00;
			endcase
			return v;
		end
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// next round key from the current one
	function automatic logic [127:0] key_step(input logic [127:0] k, input logic [3:0] r);
		logic [31:0] w0, w1, w2, w3, t;
		begin
			t  = {SBOX[k[23:16]], SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
			w0 = k[127:96] ^ t ^ {rcon(r), 24'h0};
			w1 = k[95:64] ^ w0;
			w2 = k[63:32] ^ w1;
			w3 = k[31:0] ^ w2;
			return {w0, w1, w2, w3};
		end
	endfunction

	// one AES round; byte 0 in the top bits
	function automatic logic [127:0] aes_round(input logic [127:0] st,
			input logic [127:0] rk, input logic last);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, al;
		logic [127:0] o;
		begin
			for (int i = 0; i < 16; i++)
				s[i] = SBOX[st[127-8*i -: 8]];
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++)
					t[c*4+i] = s[((c+i)%4)*4+i];
			if (!last) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
					al = a0 ^ a1 ^ a2 ^ a3;
					t[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
					t[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
					t[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
					t[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++)
				o[127-8*i -: 8] = t[i];
			return o ^ rk;
		end
	endfunction

endpackage
`default_nettype wire

/* hdl/response_cbc_mac_engine.sv */
// ----------------------------------------------------------------------------
// response_cbc_mac_engine: AES-128 CBC-MAC over secure-element responses
// Classifier, two-entry command queue and round-per-cycle cipher engine.
// ----------------------------------------------------------------------------
//
//   channel | handshake             | payload
//   --------+-----------------------+-----------------------------------------
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (key halves)
//   in      | in_valid / in_ready   | action, header, data_length, block_*,
//           |                       | status_word
//   out     | out_valid / out_ready | mac, sequence_error (end beats only)
//
// Each chained block passes the engine as a key add and 10 rounds after
// dispatch; begin chains three blocks, ciphertext one, end with a good
// count one and then posts the result.
// The single AES round unit and CBC dependency set the rate.
// Up to two beats queue ahead of the engine; a stalled result holds the
// engine but the front keeps accepting until the queue fills.
// Reset clears message state, chain and queue; the key registers clear to 0.
// Key writes take effect at the next begin that the engine starts.
`default_nettype none
module response_cbc_mac_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [31:0] header,
	input  wire logic [15:0] data_length,
	input  wire logic [63:0] block_high,
	input  wire logic [63:0] block_low,
	input  wire logic [15:0] status_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      mac,
	output logic             sequence_error
);
	import rcm_pkg::*;

	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	rcm_cmd_t    push_cmd;
	rcm_cmd_t    head;
	logic        push;
	logic        pop;
	logic        full;
	logic        not_empty;

	// config writes are to land only while idle; the block does not enforce this and has no guard
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_valid && cfg_index[1] == 1'b0) begin
			if (cfg_index[0] == REG_KEY_HIGH)
				key_high_q <= cfg_data;
			else if (cfg_index[0] == REG_KEY_LOW)
				key_low_q <= cfg_data;
		end
	end

	rcm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.header      (header),
		.data_length (data_length),
		.block_high  (block_high),
		.block_low   (block_low),
		.status_word (status_word),
		.q_full      (full),
		.q_push      (push),
		.q_cmd       (push_cmd)
	);

	rcm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	rcm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.key            ({key_high_q, key_low_q}),
		.q_not_empty    (not_empty),
		.q_head         (head),
		.q_pop          (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.mac            (mac),
		.sequence_error (sequence_error)
	);

endmodule
`default_nettype wire

/* hdl/rcm_front.sv */
// ----------------------------------------------------------------------------
// rcm_front: input classifier
// Tracks message state and block counts; queues begin, end, open cipher beats.
// ----------------------------------------------------------------------------
`default_nettype none
module rcm_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [1:0]      action,
	input  wire logic [31:0]     header,
	input  wire logic [15:0]     data_length,
	input  wire logic [63:0]     block_high,
	input  wire logic [63:0]     block_low,
	input  wire logic [15:0]     status_word,
	input  wire logic            q_full,
	output logic                 q_push,
	output rcm_pkg::rcm_cmd_t    q_cmd
);
	import rcm_pkg::*;

	logic        open_q;
	logic [12:0] expected_q;
	logic [12:0] seen_q;
	logic        acc;
	logic [16:0] len_round;

	assign in_ready  = !q_full;
	assign acc       = in_valid && in_ready;
	assign len_round = {1'b0, data_length} + 17'd15;

	always_comb begin
		q_cmd.blk = {block_high, block_low};
		q_cmd.ctx = {header, data_length, PAD_MARK, 8'h00};
		q_cmd.op  = OP_BEGIN;
		q_push    = 1'b0;
		unique case (action)
			ACT_BEGIN: begin
				q_push = acc;
			end
			ACT_CIPHER: begin
				q_cmd.op = OP_CIPHER;
				q_push   = acc && open_q;
			end
			ACT_END: begin
				q_cmd.ctx = {status_word, PAD_MARK, 40'h0};
				q_cmd.op  = (open_q && seen_q == expected_q) ? OP_END_OK : OP_END_ERR;
				q_push    = acc;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q     <= 1'b0;
			expected_q <= '0;
			seen_q     <= '0;
		end else if (acc) begin
			unique case (action)
				ACT_BEGIN: begin
					open_q     <= 1'b1;
					expected_q <= len_round[16:4];
					seen_q     <= '0;
				end
				ACT_CIPHER: begin
					if (open_q && seen_q != COUNT_MAX)
						seen_q <= seen_q + 13'd1;
				end
				ACT_END: begin
					open_q <= 1'b0;
					seen_q <= '0;
				end
				default: begin
					open_q <= open_q;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* hdl/rcm_queue.sv */
// ----------------------------------------------------------------------------
// rcm_queue: two-entry command queue
// Decouples the classifier from the cipher engine.
// ----------------------------------------------------------------------------
`default_nettype none
module rcm_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  rcm_pkg::rcm_cmd_t    push_cmd,
	output logic                 full,
	input  wire logic            pop,
	output logic                 not_empty,
	output rcm_pkg::rcm_cmd_t    head
);
	import rcm_pkg::*;

	rcm_cmd_t    mem_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

/* hdl/rcm_back.sv */
// ----------------------------------------------------------------------------
// rcm_back: CBC-MAC cipher engine
// One AES round per cycle, round keys expanded alongside; owns the chain.
// ----------------------------------------------------------------------------
`default_nettype none
module rcm_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [127:0]    key,
	input  wire logic            q_not_empty,
	input  rcm_pkg::rcm_cmd_t    q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [31:0]          mac,
	output logic                 sequence_error
);
	import rcm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_START = 4'b0010,
		S_ROUND = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	state_t       state_q;
	rcm_cmd_t     cmd_q;
	logic [127:0] chain_q;
	logic [127:0] key_q;
	logic [127:0] rk_q;
	logic [3:0]   rnd_q;
	logic [1:0]   idx_q;
	logic [127:0] blk_sel;
	logic         last_blk;
	logic         out_take;

	assign q_pop    = (state_q == S_IDLE) && q_not_empty;
	assign out_take = !out_valid || out_ready;

	always_comb begin
		priority if (cmd_q.op == OP_BEGIN && idx_q == 2'd0)
			blk_sel = DOMAIN_BLOCK;
		else if (cmd_q.op == OP_BEGIN && idx_q == 2'd2)
			blk_sel = {cmd_q.ctx, 64'h0};
		else if (cmd_q.op == OP_END_OK)
			blk_sel = {cmd_q.ctx, 64'h0};
		else
			blk_sel = cmd_q.blk;
	end

	assign last_blk = (cmd_q.op != OP_BEGIN) || (idx_q == 2'd2);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head;
			if (q_head.op == OP_BEGIN)
				key_q <= key;
		end
		if (state_q == S_START)
			rk_q <= key_step(key_q, 4'd1);
		else if (state_q == S_ROUND)
			rk_q <= key_step(rk_q, rnd_q + 4'd1);
		if (state_q == S_FIN && out_take)
			mac <= (cmd_q.op == OP_END_OK) ? chain_q[127:96] : 32'h0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			chain_q        <= '0;
			rnd_q          <= 4'd0;
			idx_q          <= 2'd0;
			out_valid      <= 1'b0;
			sequence_error <= 1'b0;
		end else begin
			// a new result may replace the one taken at this edge
			if (state_q == S_FIN && out_take)
				out_valid <= 1'b1;
			else if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_not_empty) begin
						idx_q <= 2'd0;
						if (q_head.op == OP_BEGIN)
							chain_q <= '0;
						state_q <= (q_head.op == OP_END_ERR) ? S_FIN : S_START;
					end
				end
				S_START: begin
					chain_q <= chain_q ^ blk_sel ^ key_q;
					rnd_q   <= 4'd1;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					chain_q <= aes_round(chain_q, rk_q, rnd_q == LAST_ROUND);
					rnd_q   <= rnd_q + 4'd1;
					if (rnd_q == LAST_ROUND) begin
						if (!last_blk) begin
							idx_q   <= idx_q + 2'd1;
							state_q <= S_START;
						end else if (cmd_q.op == OP_END_OK) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_FIN: begin
					if (out_take) begin
						sequence_error <= cmd_q.op == OP_END_ERR;
						chain_q        <= '0;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* sim/response_cbc_mac_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// response_cbc_mac_checker: MAC predictor and scoreboard
// Watches the config, input and result channels of the CBC-MAC engine,
// computes the expected MAC for every end beat and compares results in order.
// ----------------------------------------------------------------------------
module response_cbc_mac_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [31:0] header,
	input  wire logic [15:0] data_length,
	input  wire logic [63:0] block_high,
	input  wire logic [63:0] block_low,
	input  wire logic [15:0] status_word,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [31:0] mac,
	input  wire logic        sequence_error,
	output int               fails,
	output int               pending
);
	import rcm_pkg::*;

	typedef struct packed {
		logic [31:0] mac;
		logic        err;
	} tag_t;

	tag_t         tag_q[$];
	logic [63:0]  key_hi, key_lo;
	logic [127:0] chain;
	logic [127:0] round_keys [11];
	logic         msg_open;
	logic [12:0]  blocks_due, blocks_got;
	int           fail_cnt;

	assign fails   = fail_cnt;

	function automatic logic [7:0] dbl(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	task automatic load_schedule();
		logic [31:0] w [44];
		logic [31:0] t;
		logic [7:0]  rc;
		rc = 8'h01;
		w[0] = key_hi[63:32]; w[1] = key_hi[31:0];
		w[2] = key_lo[63:32]; w[3] = key_lo[31:0];
		for (int i = 4; i < 44; i++) begin
			t = w[i-1];
			if (i % 4 == 0) begin
				t = {SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]], SBOX[t[31:24]]}
					^ {rc, 24'h0};
				rc = dbl(rc);
			end
			w[i] = w[i-4] ^ t;
		end
		for (int r = 0; r < 11; r++)
			round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
	endtask

	// CBC step: xor block into chain, then encrypt under the stored schedule
	task automatic absorb(input logic [127:0] blk);
		logic [7:0]   s [16];
		logic [7:0]   t [16];
		logic [7:0]   x;
		logic [127:0] st;
		st = (chain ^ blk) ^ round_keys[0];
		for (int r = 1; r <= 10; r++) begin
			for (int i = 0; i < 16; i++)
				s[i] = SBOX[st[127-8*i -: 8]];
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++)
					t[c*4+i] = s[((c+i)%4)*4+i];
			if (r != 10) begin
				for (int c = 0; c < 4; c++) begin
					x = t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3];
					s[0] = t[c*4] ^ x ^ dbl(t[c*4] ^ t[c*4+1]);
					s[1] = t[c*4+1] ^ x ^ dbl(t[c*4+1] ^ t[c*4+2]);
					s[2] = t[c*4+2] ^ x ^ dbl(t[c*4+2] ^ t[c*4+3]);
					s[3] = t[c*4+3] ^ x ^ dbl(t[c*4+3] ^ t[c*4]);
					for (int i = 0; i < 4; i++)
						t[c*4+i] = s[i];
				end
			end
			for (int i = 0; i < 16; i++)
				st[127-8*i -: 8] = t[i];
			st = st ^ round_keys[r];
		end
		chain = st;
	endtask

	always @(posedge clk or negedge arst_n) begin
		tag_t       want;
		logic [16:0] len_up;
		if (!arst_n) begin
			key_hi     = '0;
			key_lo     = '0;
			chain      = '0;
			msg_open   = 1'b0;
			blocks_due = '0;
			blocks_got = '0;
			fail_cnt   = 0;
			tag_q.delete();
			pending    = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == {1'b0, REG_KEY_HIGH})
					key_hi = cfg_data;
				else if (cfg_index == {1'b0, REG_KEY_LOW})
					key_lo = cfg_data;
			end
			if (in_valid && in_ready) begin
				case (action)
					ACT_BEGIN: begin
						load_schedule();
						chain = '0;
						absorb(DOMAIN_BLOCK);
						absorb({block_high, block_low});
						absorb({header, data_length, PAD_MARK, 8'h00, 64'h0});
						len_up     = ({1'b0, data_length} + 17'd15) >> 4;
						blocks_due = len_up[12:0];
						blocks_got = '0;
						msg_open   = 1'b1;
					end
					ACT_CIPHER: begin
						if (msg_open) begin
							absorb({block_high, block_low});
							if (blocks_got < COUNT_MAX)
								blocks_got++;
						end
					end
					ACT_END: begin
						want = '{mac: 32'h0, err: 1'b1};
						if (msg_open && blocks_got == blocks_due) begin
							absorb({status_word, PAD_MARK, 40'h0, 64'h0});
							want = '{mac: chain[127:96], err: 1'b0};
						end
						tag_q.push_back(want);
						msg_open   = 1'b0;
						chain      = '0;
						blocks_got = '0;
					end
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (tag_q.size() == 0) begin
					$error("unexpected result beat: mac=%h sequence_error=%0b",
						mac, sequence_error);
					fail_cnt++;
				end else begin
					want = tag_q.pop_front();
					if (mac !== want.mac) begin
						$error("mac: expected %h, got %h", want.mac, mac);
						fail_cnt++;
					end
					if (sequence_error !== want.err) begin
						$error("sequence_error: expected %0b, got %0b",
							want.err, sequence_error);
						fail_cnt++;
					end
				end
			end
			pending = tag_q.size();
		end
	end

endmodule

/* sim/response_cbc_mac_engine_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// response_cbc_mac_engine_test: regression for the response CBC-MAC engine
// Directed sequence corner cases, then random messages under several key
// settings and idle patterns; a checker beside the block scores the results.
// ----------------------------------------------------------------------------
module response_cbc_mac_engine_test;
	import rcm_pkg::*;

	localparam logic [1:0] ACT_NONE   = 2'd3;  // undefined action, dropped
	localparam int         CYCLE_CAP  = 2000000;
	localparam int         DRAIN_WAIT = 200;   // lets queued begin and cipher beats finish
	localparam int         HOLD_LEN   = 400;

	logic        clk, arst_n;
	logic        cfg_valid, cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid, in_ready;
	logic [1:0]  action;
	logic [31:0] header;
	logic [15:0] data_length;
	logic [63:0] block_high, block_low;
	logic [15:0] status_word;
	logic        out_valid, out_ready;
	logic [31:0] mac;
	logic        sequence_error;

	int fails, pending;
	int beats_sent;
	int send_idle_pct, recv_stall_pct;
	bit hold_req, hold_done;
	int cycle_cnt;

	response_cbc_mac_engine dut (.*);

	response_cbc_mac_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random stalls, plus one long hold-off when requested so
	// the two-entry queue fills and input ready drops
	initial begin
		int hold_cnt;
		out_ready = 1'b0;
		hold_done = 1'b0;
		hold_cnt  = 0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				hold_cnt++;
				if (hold_cnt >= HOLD_LEN)
					hold_done = 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_CAP) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// one input beat; called just after a rising edge, returns at the
	// edge where the beat is taken; valid stays up for back-to-back beats
	task automatic send(input logic [1:0] act, input logic [31:0] hdr,
			input logic [15:0] len, input logic [63:0] bh, input logic [63:0] bl,
			input logic [15:0] sw);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 40)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		header      <= hdr;
		data_length <= len;
		block_high  <= bh;
		block_low   <= bl;
		status_word <= sw;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	task automatic send_begin(input logic [15:0] len);
		send(ACT_BEGIN, $urandom, len, rand64(), rand64(), 16'($urandom));
	endtask

	task automatic send_cipher();
		send(ACT_CIPHER, $urandom, 16'($urandom), rand64(), rand64(), 16'($urandom));
	endtask

	task automatic send_end();
		send(ACT_END, $urandom, 16'($urandom), rand64(), rand64(), 16'($urandom));
	endtask

	// key writes only when idle: all results in, then let dropped beats drain
	task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= {1'b0, REG_KEY_HIGH};
		cfg_data  <= hi;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= {1'b0, REG_KEY_LOW};
		cfg_data  <= lo;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// well-formed message, sometimes one block short or long, or a long length with up to six blocks
	task automatic random_message();
		logic [15:0] len;
		int nblk;
		if ($urandom_range(19) == 0)
			len = 16'($urandom);          // long length, usually ends in error
		else
			len = 16'($urandom_range(80));
		nblk = (int'(len) + 15) / 16;
		if (nblk > 6)
			nblk = $urandom_range(6);
		else if ($urandom_range(9) == 0)
			nblk = nblk + ($urandom_range(1) ? 1 : (nblk > 0 ? -1 : 1));
		send_begin(len);
		repeat (nblk) send_cipher();
		send_end();
	endtask

	initial begin
		int phase_end;
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		in_valid       = 1'b0;
		action         = ACT_BEGIN;
		header         = '0;
		data_length    = '0;
		block_high     = '0;
		block_low      = '0;
		status_word    = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b0;
		beats_sent     = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed: reset key (all zero), sequence corners ---
		send(ACT_END, '0, '0, '0, '0, 16'h9000);              // end, nothing open
		send(ACT_CIPHER, '0, '0, '1, '1, '0);                 // cipher, nothing open
		send(ACT_NONE, '1, '1, '1, '1, '1);                   // undefined action
		send(ACT_BEGIN, '0, 16'd0, '0, '0, '0);               // empty ciphertext
		send(ACT_END, '0, '0, '0, '0, 16'h0000);
		send(ACT_BEGIN, '1, 16'd16, '1, '1, '1);              // one full block
		send(ACT_CIPHER, '1, '1, '1, '1, '1);
		send(ACT_END, '1, '1, '1, '1, 16'hFFFF);
		write_key('1, '1);
		send(ACT_BEGIN, 32'h80CA_0000, 16'd17, rand64(), rand64(), '0);
		send_cipher();                                        // one short
		send_end();
		send_begin(16'd32);                                   // abandoned by begin
		send_cipher();
		send_begin(16'd1);
		send_cipher();
		send_cipher();                                        // extra block
		send_end();
		send(ACT_BEGIN, $urandom, 16'hFFFF, rand64(), rand64(), '0);  // max length
		send_cipher();
		send_end();
		send_begin(16'd48);                                   // exact, three blocks
		repeat (3) send_cipher();
		send_end();

		// --- random: four idle patterns, new key each phase ---
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			write_key(ph == 3 ? 64'h0 : rand64(), ph == 3 ? 64'h0 : rand64());
			if (ph == 0)
				hold_req = 1'b1;      // long receiver hold-off at start
			phase_end = beats_sent + 350;
			while (beats_sent < phase_end) begin
				if ($urandom_range(9) == 0)
					send(2'($urandom_range(3)), $urandom, 16'($urandom), rand64(),
						rand64(), 16'($urandom));
				else
					random_message();
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
